// ===== rtl/adsr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package adsr_pkg;

   localparam int COUNT_BITS_DEF = 24;
   localparam int SETTING_W      = 24;
   localparam int PLAYED_W       = 24;
   localparam int TOTAL_W        = 25;
   localparam int WAVE_W         = 16;
   localparam int GAIN_W         = 17;
   localparam int FRAC_BITS      = 16;
   localparam int RATE_W         = 17;
   localparam int KDIV_W         = 10;
   localparam int CSR_IDX_W      = 3;
   localparam int CSR_DATA_W     = 24;
   localparam int CNT_STAGES     = 4;

   localparam logic [GAIN_W-1:0] FULL_GAIN   = 17'h10000;
   localparam logic [KDIV_W-1:0] DIV_MS      = 10'd1000;
   localparam logic [KDIV_W-1:0] DIV_PCT     = 10'd100;
   localparam logic [KDIV_W-1:0] DIV_RAW     = 10'd1;
   localparam logic [RATE_W-1:0] RATE_RESET  = 17'd44100;

   localparam logic [CSR_IDX_W-1:0] CSR_ATTACK  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DECAY   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RELEASE = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SUSTAIN = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_UNIT    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_RATE    = 3'd5;

   localparam logic [1:0] UNIT_RAW = 2'd0;
   localparam logic [1:0] UNIT_MS  = 2'd1;
   localparam logic [1:0] UNIT_PCT = 2'd2;

   typedef enum logic [1:0] {
      PH_ATTACK,
      PH_DECAY,
      PH_RELEASE,
      PH_SUSTAIN
   } phase_type;

   typedef struct packed {
      logic signed [WAVE_W-1:0] w;
      logic [PLAYED_W-1:0]      i;
      logic [TOTAL_W-1:0]       t;
      logic                     silent;
   } side_type;

   typedef struct packed {
      logic signed [WAVE_W-1:0] w;
      logic                     silent;
      phase_type                phase;
   } tail_type;

endpackage

`default_nettype wire

// ===== rtl/adsr_cnt_div.sv =====
`timescale 1ns / 1ps
`default_nettype none

module adsr_cnt_div #(
   parameter int COUNT_BITS = adsr_pkg::COUNT_BITS_DEF
) (
   input  wire logic                           clock,
   input  wire logic                           en,
   input  wire logic [adsr_pkg::SETTING_W-1:0] setting,
   input  wire logic [adsr_pkg::TOTAL_W-1:0]   mul,
   input  wire logic [adsr_pkg::KDIV_W-1:0]    k,
   output logic [COUNT_BITS-1:0]               count
);

   localparam int PW = adsr_pkg::SETTING_W + adsr_pkg::TOTAL_W;
   localparam int KW = adsr_pkg::KDIV_W;
   // below saturation the product fits in SW bits
   localparam int SW = COUNT_BITS + KW;
   localparam int HW = SW / 2;
   localparam int RW = SW - 6;
   localparam int QW = SW + RW + 1;

   localparam logic [RW-1:0] RECIP_MS  = RW'((64'd1 << SW) / 64'd1000);
   localparam logic [RW-1:0] RECIP_PCT = RW'((64'd1 << SW) / 64'd100);

   logic [PW-1:0] p_ff;
   logic [KW-1:0] km_ff;
   logic [RW-1:0] recip;

   logic                  sat1_ff, raw1_ff;
   logic [SW-1:0]         p1_ff;
   logic [KW-1:0]         k1_ff;
   logic [SW-HW+RW-1:0]   hi1_ff;
   logic [HW+RW-1:0]      lo1_ff;

   logic                  sat2_ff;
   logic [SW-1:0]         p2_ff;
   logic [KW-1:0]         k2_ff;
   logic [COUNT_BITS-1:0] qe2_ff;
   logic [QW-1:0]         sum;

   logic                  sat3_ff, inc3_ff;
   logic [COUNT_BITS-1:0] q3_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         p_ff  <= PW'(setting) * PW'(mul);
         km_ff <= k;
      end
   end

   assign recip = (km_ff == adsr_pkg::DIV_MS) ? RECIP_MS : RECIP_PCT;

   // quotient must fit in COUNT_BITS, otherwise saturate
   always_ff @(posedge clock) begin
      if (en) begin
         sat1_ff <= p_ff[PW-1:COUNT_BITS] >= (PW-COUNT_BITS)'(km_ff);
         raw1_ff <= km_ff == adsr_pkg::DIV_RAW;
         p1_ff   <= p_ff[SW-1:0];
         k1_ff   <= km_ff;
         hi1_ff  <= (SW-HW+RW)'(p_ff[SW-1:HW]) * (SW-HW+RW)'(recip);
         lo1_ff  <= (HW+RW)'(p_ff[HW-1:0]) * (HW+RW)'(recip);
      end
   end

   // reciprocal estimate is low by at most one
   assign sum = (QW'(hi1_ff) << HW) + QW'(lo1_ff);

   always_ff @(posedge clock) begin
      if (en) begin
         sat2_ff <= sat1_ff;
         p2_ff   <= p1_ff;
         k2_ff   <= k1_ff;
         qe2_ff  <= raw1_ff ? p1_ff[COUNT_BITS-1:0] : sum[SW+COUNT_BITS-1:SW];
      end
   end

   // bump the estimate when the remainder still holds a whole divisor
   always_ff @(posedge clock) begin
      if (en) begin
         sat3_ff <= sat2_ff;
         q3_ff   <= qe2_ff;
         inc3_ff <= (p2_ff - SW'(qe2_ff) * SW'(k2_ff)) >= SW'(k2_ff);
      end
   end

   assign count = sat3_ff ? '1 : q3_ff + COUNT_BITS'(inc3_ff);

endmodule

`default_nettype wire

// ===== rtl/adsr_frac_div.sv =====
`timescale 1ns / 1ps
`default_nettype none

module adsr_frac_div #(
   parameter int COUNT_BITS = adsr_pkg::COUNT_BITS_DEF
) (
   input  wire logic                        clock,
   input  wire logic                        en,
   input  wire logic [COUNT_BITS-1:0]       x,
   input  wire logic [COUNT_BITS-1:0]       den,
   output logic [adsr_pkg::GAIN_W-1:0]      f
);

   localparam int FB = adsr_pkg::FRAC_BITS;
   localparam int GW = adsr_pkg::GAIN_W;

   logic [COUNT_BITS-1:0] rem_ff [0:FB];
   logic [COUNT_BITS-1:0] den_ff [0:FB];
   logic [GW-1:0]         q_ff   [0:FB];

   // x never exceeds den, so the integer quotient bit is x == den
   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0] <= (x == den) ? '0 : x;
         den_ff[0] <= den;
         q_ff[0]   <= GW'(x == den);
      end
   end

   for (genvar j = 1; j <= FB; j++) begin : g_bit
      logic [COUNT_BITS:0]   r2;
      logic                  ge;
      logic [COUNT_BITS-1:0] rem_in;

      always_comb begin
         r2     = {rem_ff[j-1], 1'b0};
         ge     = r2 >= {1'b0, den_ff[j-1]};
         rem_in = ge ? COUNT_BITS'(r2 - {1'b0, den_ff[j-1]}) : r2[COUNT_BITS-1:0];
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[j] <= rem_in;
            den_ff[j] <= den_ff[j-1];
            q_ff[j]   <= {q_ff[j-1][GW-2:0], ge};
         end
      end
   end

   assign f = q_ff[FB];

endmodule

`default_nettype wire

// ===== rtl/adsr_wavetable_sample_shaper_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Envelope shaper for wavetable samples.
// Request beat: wave_sample (Q1.15), played and remaining sample counts of
// the tone, and a silent flag. Response beat: out_sample = gain * wave *
// 32767 / 2^31, truncated toward zero, gain following attack, decay,
// sustain and release. Settings are written over the csr port (always
// ready); the user must write them only while no beats are in flight, as
// the block does not enforce it. Stages: one input stage, four stages that
// turn settings into sample counts (product, reciprocal partial products,
// sum and a one-step correction), two phase select stages, 17 stages of
// fractional division one bit per stage, and five gain and output stages.
// Throughput is one beat per cycle while the response is not stalled.
// Reset clears every valid bit and loads the register defaults.
// While the response is stalled with a beat waiting, the whole pipeline
// holds and req_stall is raised; nothing is dropped or repeated.
module adsr_wavetable_sample_shaper_core #(
   parameter int COUNT_BITS = adsr_pkg::COUNT_BITS_DEF
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_valid,
   output logic                                       req_stall,
   input  wire logic signed [adsr_pkg::WAVE_W-1:0]    req_wave_sample,
   input  wire logic [adsr_pkg::PLAYED_W-1:0]         req_played,
   input  wire logic [adsr_pkg::PLAYED_W-1:0]         req_remaining,
   input  wire logic                                  req_silent,
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_stall,
   output logic signed [adsr_pkg::WAVE_W-1:0]         rsp_out_sample,
   input  wire logic                                  csr_valid,
   output logic                                       csr_ready,
   input  wire logic [adsr_pkg::CSR_IDX_W-1:0]        csr_index,
   input  wire logic [adsr_pkg::CSR_DATA_W-1:0]       csr_data
);

   localparam int LC = adsr_pkg::CNT_STAGES;
   localparam int LF = adsr_pkg::FRAC_BITS + 1;
   localparam int GW = adsr_pkg::GAIN_W;
   localparam int WW = adsr_pkg::WAVE_W;
   localparam int XW = ((COUNT_BITS > adsr_pkg::PLAYED_W) ?
                        COUNT_BITS : adsr_pkg::PLAYED_W) + 2;
   localparam int MW = 2 * GW;
   localparam int PW = GW + 1 + WW;
   localparam int EW = PW + 15;

   logic en;

   // registers
   logic [adsr_pkg::SETTING_W-1:0] attack_ff, decay_ff, release_ff;
   logic [GW-1:0]                  sustain_ff;
   logic [1:0]                     unit_ff;
   logic [adsr_pkg::RATE_W-1:0]    rate_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         attack_ff  <= '0;
         decay_ff   <= '0;
         release_ff <= '0;
         sustain_ff <= adsr_pkg::FULL_GAIN;
         unit_ff    <= adsr_pkg::UNIT_RAW;
         rate_ff    <= adsr_pkg::RATE_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            adsr_pkg::CSR_ATTACK:  attack_ff  <= csr_data;
            adsr_pkg::CSR_DECAY:   decay_ff   <= csr_data;
            adsr_pkg::CSR_RELEASE: release_ff <= csr_data;
            adsr_pkg::CSR_SUSTAIN: sustain_ff <= csr_data[GW-1:0];
            adsr_pkg::CSR_UNIT:    unit_ff    <= csr_data[1:0];
            adsr_pkg::CSR_RATE:    rate_ff    <= csr_data[adsr_pkg::RATE_W-1:0];
            default: ;
         endcase
      end
   end

   logic [GW-1:0] s_eff;
   assign s_eff = (sustain_ff > adsr_pkg::FULL_GAIN) ? adsr_pkg::FULL_GAIN : sustain_ff;

   // hold everything while a finished beat waits
   assign en        = !(rsp_valid && rsp_stall);
   assign req_stall = !en;

   // input stage
   logic               va_ff;
   adsr_pkg::side_type side_a_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
      end else if (en) begin
         va_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side_a_ff.w      <= req_wave_sample;
         side_a_ff.i      <= req_played;
         side_a_ff.t      <= adsr_pkg::TOTAL_W'(req_played) +
                             adsr_pkg::TOTAL_W'(req_remaining);
         side_a_ff.silent <= req_silent;
      end
   end

   // unit conversion
   logic [adsr_pkg::TOTAL_W-1:0] mul;
   logic [adsr_pkg::KDIV_W-1:0]  kdiv;

   always_comb begin
      case (unit_ff)
         adsr_pkg::UNIT_MS: begin
            mul  = adsr_pkg::TOTAL_W'(rate_ff);
            kdiv = adsr_pkg::DIV_MS;
         end
         adsr_pkg::UNIT_PCT: begin
            mul  = side_a_ff.t;
            kdiv = adsr_pkg::DIV_PCT;
         end
         default: begin
            mul  = adsr_pkg::TOTAL_W'(1);
            kdiv = adsr_pkg::DIV_RAW;
         end
      endcase
   end

   logic [COUNT_BITS-1:0] a_cnt, d_cnt, r_cnt;

   adsr_cnt_div #(.COUNT_BITS(COUNT_BITS)) u_cnt_attack (
      .clock(clock), .en(en), .setting(attack_ff), .mul(mul), .k(kdiv), .count(a_cnt)
   );
   adsr_cnt_div #(.COUNT_BITS(COUNT_BITS)) u_cnt_decay (
      .clock(clock), .en(en), .setting(decay_ff), .mul(mul), .k(kdiv), .count(d_cnt)
   );
   adsr_cnt_div #(.COUNT_BITS(COUNT_BITS)) u_cnt_release (
      .clock(clock), .en(en), .setting(release_ff), .mul(mul), .k(kdiv), .count(r_cnt)
   );

   logic               vc_ff     [0:LC-1];
   adsr_pkg::side_type side_c_ff [0:LC-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j < LC; j++) vc_ff[j] <= 1'b0;
      end else if (en) begin
         vc_ff[0] <= va_ff;
         for (int j = 1; j < LC; j++) vc_ff[j] <= vc_ff[j-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side_c_ff[0] <= side_a_ff;
         for (int j = 1; j < LC; j++) side_c_ff[j] <= side_c_ff[j-1];
      end
   end

   // phase boundaries
   logic                  vp1_ff;
   adsr_pkg::side_type    side1_ff;
   logic [COUNT_BITS-1:0] a1_ff, d1_ff, r1_ff;
   logic [XW-1:0]         ad1_ff, ir1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vp1_ff <= 1'b0;
      end else if (en) begin
         vp1_ff <= vc_ff[LC-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side1_ff <= side_c_ff[LC-1];
         a1_ff    <= a_cnt;
         d1_ff    <= d_cnt;
         r1_ff    <= r_cnt;
         ad1_ff   <= XW'(a_cnt) + XW'(d_cnt);
         ir1_ff   <= XW'(side_c_ff[LC-1].i) + XW'(r_cnt);
      end
   end

   // phase select
   logic [XW-1:0]         i_x, a_x, t_x, x_full;
   logic [COUNT_BITS-1:0] den;
   adsr_pkg::phase_type   phase;

   always_comb begin
      i_x = XW'(side1_ff.i);
      a_x = XW'(a1_ff);
      t_x = XW'(side1_ff.t);
      if (i_x < a_x) begin
         phase  = adsr_pkg::PH_ATTACK;
         x_full = i_x;
         den    = a1_ff;
      end else if (i_x < ad1_ff) begin
         phase  = adsr_pkg::PH_DECAY;
         x_full = i_x - a_x;
         den    = d1_ff;
      end else if (ir1_ff > t_x) begin
         phase  = adsr_pkg::PH_RELEASE;
         x_full = ir1_ff - t_x;
         den    = r1_ff;
      end else begin
         phase  = adsr_pkg::PH_SUSTAIN;
         x_full = '0;
         den    = '0;
      end
   end

   logic                  vp2_ff;
   logic [COUNT_BITS-1:0] x2_ff, den2_ff;
   adsr_pkg::tail_type    tail2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vp2_ff <= 1'b0;
      end else if (en) begin
         vp2_ff <= vp1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x2_ff           <= x_full[COUNT_BITS-1:0];
         den2_ff         <= den;
         tail2_ff.w      <= side1_ff.w;
         tail2_ff.silent <= side1_ff.silent;
         tail2_ff.phase  <= phase;
      end
   end

   // fraction within the phase
   logic [GW-1:0] f_div;

   adsr_frac_div #(.COUNT_BITS(COUNT_BITS)) u_frac_div (
      .clock(clock), .en(en), .x(x2_ff), .den(den2_ff), .f(f_div)
   );

   logic               vf_ff     [0:LF-1];
   adsr_pkg::tail_type tail_f_ff [0:LF-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j < LF; j++) vf_ff[j] <= 1'b0;
      end else if (en) begin
         vf_ff[0] <= vp2_ff;
         for (int j = 1; j < LF; j++) vf_ff[j] <= vf_ff[j-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         tail_f_ff[0] <= tail2_ff;
         for (int j = 1; j < LF; j++) tail_f_ff[j] <= tail_f_ff[j-1];
      end
   end

   // gain
   logic               vg1_ff, vg2_ff, vg3_ff, vg4_ff;
   adsr_pkg::tail_type tg1_ff, tg2_ff, tg3_ff, tg4_ff;
   logic [MW-1:0]      m1_ff;
   logic [GW-1:0]      f1_ff, g2_ff, g_in, mul_a;
   logic signed [PW-1:0] gw3_ff;
   logic signed [EW-1:0] p4_ff, gw_x;

   always_ff @(posedge clock) begin
      if (reset) begin
         vg1_ff <= 1'b0;
         vg2_ff <= 1'b0;
         vg3_ff <= 1'b0;
         vg4_ff <= 1'b0;
      end else if (en) begin
         vg1_ff <= vf_ff[LF-1];
         vg2_ff <= vg1_ff;
         vg3_ff <= vg2_ff;
         vg4_ff <= vg3_ff;
      end
   end

   assign mul_a = (tail_f_ff[LF-1].phase == adsr_pkg::PH_DECAY) ?
                  f_div : GW'(adsr_pkg::FULL_GAIN - f_div);

   always_comb begin
      case (tg1_ff.phase)
         adsr_pkg::PH_ATTACK:  g_in = f1_ff;
         adsr_pkg::PH_DECAY:   g_in = GW'(adsr_pkg::FULL_GAIN - f1_ff + m1_ff[MW-1:16]);
         adsr_pkg::PH_RELEASE: g_in = m1_ff[GW+15:16];
         default:              g_in = s_eff;
      endcase
   end

   assign gw_x = EW'(gw3_ff);

   always_ff @(posedge clock) begin
      if (en) begin
         m1_ff  <= MW'(mul_a * s_eff);
         f1_ff  <= f_div;
         tg1_ff <= tail_f_ff[LF-1];
         g2_ff  <= g_in;
         tg2_ff <= tg1_ff;
         gw3_ff <= PW'($signed({1'b0, g2_ff}) * tg2_ff.w);
         tg3_ff <= tg2_ff;
         p4_ff  <= (gw_x <<< 15) - gw_x;
         tg4_ff <= tg3_ff;
      end
   end

   // truncate toward zero
   logic          neg;
   logic [EW-1:0] mag;
   logic [WW-1:0] sh;

   always_comb begin
      neg = p4_ff[EW-1];
      mag = neg ? EW'(-p4_ff) : EW'(p4_ff);
      sh  = mag[31+WW-1:31];
   end

   logic                 rsp_valid_ff;
   logic signed [WW-1:0] rsp_out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= vg4_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_out_ff <= tg4_ff.silent ? '0 : (neg ? WW'(-sh) : sh);
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_sample = rsp_out_ff;

endmodule

`default_nettype wire
